// ===== rtl/tsn_pkg.sv =====
// Shared constants for the tile surface normal block.
package tsn_pkg;

    localparam int HEIGHT_FRAC_BITS = 8;
    localparam int NORMAL_FRAC_BITS = 14;
    localparam int TILE_SIDE        = 10;
    localparam int UNIT_FRAC_BITS   = 24;
    localparam int CORNER_W         = 24;
    localparam int NORMAL_W         = 16;
    localparam int LEN_W            = 62;
    localparam int ROOT_W           = 31;
    localparam int SHIFT_W          = 5;
    localparam int NORM_STEPS       = 5;

endpackage

// ===== rtl/tsn_norm.sv =====
// Pipelined 3-vector normalizer: squared length, pair shift, square root, division.
module tsn_norm #(
    parameter int CW = 25,
    parameter int F  = 24
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  logic signed [CW-1:0] i_x,
    input  logic signed [CW-1:0] i_y,
    input  logic signed [CW-1:0] i_z,
    output logic                 o_valid,
    output logic signed [F+1:0]  o_x,
    output logic signed [F+1:0]  o_y,
    output logic signed [F+1:0]  o_z
);

    localparam int QW    = F + 1;
    localparam int OW    = F + 2;
    localparam int NW    = F + 32;
    localparam int LW    = tsn_pkg::LEN_W;
    localparam int RW    = tsn_pkg::ROOT_W;
    localparam int SW    = tsn_pkg::SHIFT_W;
    localparam int NSTEP = tsn_pkg::NORM_STEPS;
    localparam int DRW   = 32;

    typedef struct packed {
        logic [2:0]         neg;
        logic [2:0][CW-1:0] mag;
    } t_carry;

    // input: sign and magnitude
    logic signed [CW-1:0] comp [3];
    t_carry               n_in;
    t_carry               r_in;
    logic                 r_in_v;

    assign comp[0] = i_x;
    assign comp[1] = i_y;
    assign comp[2] = i_z;

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            n_in.neg[c] = comp[c][CW-1];
            n_in.mag[c] = comp[c][CW-1] ? CW'(-comp[c]) : comp[c];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v <= 1'b0;
        end else begin
            r_in_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_in <= n_in;
    end

    // squares
    logic [2*CW-1:0] r_sqr [3];
    t_carry          r_c1;
    logic            r_v1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else begin
            r_v1 <= r_in_v;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int c = 0; c < 3; c++) begin
            r_sqr[c] <= (2*CW)'(r_in.mag[c]) * (2*CW)'(r_in.mag[c]);
        end
        r_c1 <= r_in;
    end

    // squared length
    logic [LW-1:0] r_len;
    t_carry        r_c2;
    logic          r_v2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_len <= LW'(r_sqr[0]) + LW'(r_sqr[1]) + LW'(r_sqr[2]);
        r_c2  <= r_c1;
    end

    // shift by pairs of bits until the length reaches bit 60 or 61
    logic [LW-1:0] nm_len [NSTEP];
    logic [SW-1:0] nm_s   [NSTEP];
    t_carry        nm_c   [NSTEP];
    logic          nm_v   [NSTEP];

    for (genvar k = 0; k < NSTEP; k++) begin : g_nm
        localparam int P = 16 >> k;
        logic [LW-1:0] len_in;
        logic [SW-1:0] s_in;
        t_carry        c_in;
        logic          v_in;

        if (k == 0) begin : g_first
            assign len_in = r_len;
            assign s_in   = '0;
            assign c_in   = r_c2;
            assign v_in   = r_v2;
        end else begin : g_next
            assign len_in = nm_len[k-1];
            assign s_in   = nm_s[k-1];
            assign c_in   = nm_c[k-1];
            assign v_in   = nm_v[k-1];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                nm_v[k] <= 1'b0;
            end else begin
                nm_v[k] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (len_in[LW-1 -: 2*P] == '0) begin
                nm_len[k] <= len_in << (2*P);
                nm_s[k]   <= s_in + SW'(P);
            end else begin
                nm_len[k] <= len_in;
                nm_s[k]   <= s_in;
            end
            nm_c[k] <= c_in;
        end
    end

    // square root, one bit per stage
    logic [LW:0]   sq_rem  [RW];
    logic [RW-1:0] sq_root [RW];
    logic [SW-1:0] sq_s    [RW];
    t_carry        sq_c    [RW];
    logic          sq_v    [RW];

    for (genvar i = 0; i < RW; i++) begin : g_sq
        localparam int B = RW - 1 - i;
        logic [LW:0]   rem_in;
        logic [RW-1:0] root_in;
        logic [SW-1:0] s_in;
        t_carry        c_in;
        logic          v_in;
        logic [LW:0]   trial;

        if (i == 0) begin : g_first
            assign rem_in  = (LW+1)'(nm_len[NSTEP-1]);
            assign root_in = '0;
            assign s_in    = nm_s[NSTEP-1];
            assign c_in    = nm_c[NSTEP-1];
            assign v_in    = nm_v[NSTEP-1];
        end else begin : g_next
            assign rem_in  = sq_rem[i-1];
            assign root_in = sq_root[i-1];
            assign s_in    = sq_s[i-1];
            assign c_in    = sq_c[i-1];
            assign v_in    = sq_v[i-1];
        end

        assign trial = ((LW+1)'(root_in) << (B + 1)) + ((LW+1)'(1) << (2*B));

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                sq_v[i] <= 1'b0;
            end else begin
                sq_v[i] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (rem_in >= trial) begin
                sq_rem[i]  <= rem_in - trial;
                sq_root[i] <= root_in | (RW'(1) << B);
            end else begin
                sq_rem[i]  <= rem_in;
                sq_root[i] <= root_in;
            end
            sq_s[i] <= s_in;
            sq_c[i] <= c_in;
        end
    end

    // dividends: |c| * 2^(s+F) plus half the root for rounding
    logic [NW-1:0] r_num [3];
    logic [RW-1:0] r_nr;
    logic [2:0]    r_nneg;
    logic          r_nv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nv <= 1'b0;
        end else begin
            r_nv <= sq_v[RW-1];
        end
    end

    always_ff @(posedge i_clk) begin
        for (int c = 0; c < 3; c++) begin
            r_num[c] <= ((NW'(sq_c[RW-1].mag[c]) << sq_s[RW-1]) << F)
                        + NW'(sq_root[RW-1] >> 1);
        end
        r_nr   <= sq_root[RW-1];
        r_nneg <= sq_c[RW-1].neg;
    end

    // restoring division, one quotient bit per stage, three lanes
    logic [DRW-1:0] dv_rem [QW][3];
    logic [NW-1:0]  dv_num [QW][3];
    logic [QW-1:0]  dv_q   [QW][3];
    logic [RW-1:0]  dv_r   [QW];
    logic [2:0]     dv_neg [QW];
    logic           dv_v   [QW];

    for (genvar j = 0; j < QW; j++) begin : g_dv
        localparam int B = QW - 1 - j;
        logic [DRW-1:0] rem_in [3];
        logic [NW-1:0]  num_in [3];
        logic [QW-1:0]  q_in   [3];
        logic [RW-1:0]  r_in_d;
        logic [2:0]     neg_in;
        logic           v_in;

        if (j == 0) begin : g_first
            always_comb begin
                for (int c = 0; c < 3; c++) begin
                    rem_in[c] = DRW'(r_num[c][NW-1:QW]);
                    num_in[c] = r_num[c];
                    q_in[c]   = '0;
                end
            end
            assign r_in_d = r_nr;
            assign neg_in = r_nneg;
            assign v_in   = r_nv;
        end else begin : g_next
            always_comb begin
                for (int c = 0; c < 3; c++) begin
                    rem_in[c] = dv_rem[j-1][c];
                    num_in[c] = dv_num[j-1][c];
                    q_in[c]   = dv_q[j-1][c];
                end
            end
            assign r_in_d = dv_r[j-1];
            assign neg_in = dv_neg[j-1];
            assign v_in   = dv_v[j-1];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                dv_v[j] <= 1'b0;
            end else begin
                dv_v[j] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            logic [DRW:0] t;
            for (int c = 0; c < 3; c++) begin
                t = {rem_in[c], num_in[c][B]};
                if (t >= (DRW+1)'(r_in_d)) begin
                    dv_rem[j][c] <= DRW'(t - (DRW+1)'(r_in_d));
                    dv_q[j][c]   <= q_in[c] | (QW'(1) << B);
                end else begin
                    dv_rem[j][c] <= DRW'(t);
                    dv_q[j][c]   <= q_in[c];
                end
                dv_num[j][c] <= num_in[c];
            end
            dv_r[j]   <= r_in_d;
            dv_neg[j] <= neg_in;
        end
    end

    // restore signs
    logic signed [OW-1:0] r_out [3];
    logic                 r_ov;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else begin
            r_ov <= dv_v[QW-1];
        end
    end

    always_ff @(posedge i_clk) begin
        logic signed [OW-1:0] q;
        for (int c = 0; c < 3; c++) begin
            q = $signed({1'b0, dv_q[QW-1][c]});
            r_out[c] <= dv_neg[QW-1][c] ? -q : q;
        end
    end

    assign o_valid = r_ov;
    assign o_x     = r_out[0];
    assign o_y     = r_out[1];
    assign o_z     = r_out[2];

endmodule

// ===== rtl/tile_surface_normal.sv =====
// Top level: unit surface normal of one square terrain tile from its corner heights.
//
// One tile is taken on every cycle that start is high; busy never rises and the block
// never stalls. The normal comes out on o_valid behind an input register, two triangle
// normalizers side by side, a sum register and a final normalizer. Each normalizer holds
// five pair-shift steps, a 31-stage square root and an f+1 stage restoring divider, with
// f = 24 for the triangles and f = NORMAL_FRAC_BITS for the last. Results cannot be
// held off; the receiver must take each word in the cycle o_valid is high.
module tile_surface_normal #(
    parameter int HEIGHT_FRAC_BITS = tsn_pkg::HEIGHT_FRAC_BITS,
    parameter int NORMAL_FRAC_BITS = tsn_pkg::NORMAL_FRAC_BITS
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic signed [tsn_pkg::CORNER_W-1:0]   i_corner_top_left,
    input  logic signed [tsn_pkg::CORNER_W-1:0]   i_corner_top_right,
    input  logic signed [tsn_pkg::CORNER_W-1:0]   i_corner_bottom_left,
    input  logic signed [tsn_pkg::CORNER_W-1:0]   i_corner_bottom_right,
    output logic                                  o_valid,
    output logic signed [tsn_pkg::NORMAL_W-1:0]   o_normal_x,
    output logic signed [tsn_pkg::NORMAL_W-1:0]   o_normal_y,
    output logic signed [tsn_pkg::NORMAL_W-1:0]   o_normal_z
);

    localparam int DW   = tsn_pkg::CORNER_W + 1;
    localparam int UF   = tsn_pkg::UNIT_FRAC_BITS;
    localparam int UW   = UF + 2;
    localparam int SUMW = UW + 1;
    localparam int OW   = NORMAL_FRAC_BITS + 2;
    localparam int TH   = tsn_pkg::TILE_SIDE << HEIGHT_FRAC_BITS;
    localparam logic signed [DW-1:0] NEG_T = DW'(-TH);

    assign busy = 1'b0;

    // triangle directions
    logic                 r_dv;
    logic signed [DW-1:0] r_ax, r_az, r_bx, r_bz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv <= 1'b0;
        end else begin
            r_dv <= start & ~busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ax <= DW'(i_corner_bottom_right) - DW'(i_corner_bottom_left);
        r_az <= DW'(i_corner_top_left) - DW'(i_corner_bottom_left);
        r_bx <= DW'(i_corner_top_right) - DW'(i_corner_top_left);
        r_bz <= DW'(i_corner_top_right) - DW'(i_corner_bottom_right);
    end

    logic                 v_a, v_b;
    logic signed [UW-1:0] ua_x, ua_y, ua_z, ub_x, ub_y, ub_z;

    tsn_norm #(.CW(DW), .F(UF)) u_norm_a (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_dv),
        .i_x     (r_ax),
        .i_y     (NEG_T),
        .i_z     (r_az),
        .o_valid (v_a),
        .o_x     (ua_x),
        .o_y     (ua_y),
        .o_z     (ua_z)
    );

    tsn_norm #(.CW(DW), .F(UF)) u_norm_b (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_dv),
        .i_x     (r_bx),
        .i_y     (NEG_T),
        .i_z     (r_bz),
        .o_valid (v_b),
        .o_x     (ub_x),
        .o_y     (ub_y),
        .o_z     (ub_z)
    );

    // sum of the two unit normals
    logic                   r_sv;
    logic signed [SUMW-1:0] r_sx, r_sy, r_sz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sv <= 1'b0;
        end else begin
            r_sv <= v_a;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sx <= SUMW'(ua_x) + SUMW'(ub_x);
        r_sy <= SUMW'(ua_y) + SUMW'(ub_y);
        r_sz <= SUMW'(ua_z) + SUMW'(ub_z);
    end

    logic                 v_n;
    logic signed [OW-1:0] n_x, n_y, n_z;

    tsn_norm #(.CW(SUMW), .F(NORMAL_FRAC_BITS)) u_norm_n (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_sv),
        .i_x     (r_sx),
        .i_y     (r_sy),
        .i_z     (r_sz),
        .o_valid (v_n),
        .o_x     (n_x),
        .o_y     (n_y),
        .o_z     (n_z)
    );

    assign o_valid    = v_n;
    assign o_normal_x = tsn_pkg::NORMAL_W'(n_x);
    assign o_normal_y = tsn_pkg::NORMAL_W'(n_y);
    assign o_normal_z = tsn_pkg::NORMAL_W'(n_z);

    // both triangle normalizers must stay in lockstep
    ap_lanes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        v_a == v_b)
        else $error("triangle normalizer valids diverged");

    ap_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sv == $past(v_a))
        else $error("sum stage valid lost or invented");

    // y of each triangle is -T, so its unit y must come out negative
    ap_ya: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (v_a |-> (ua_y < 0 && ub_y < 0)))
        else $error("triangle unit normal y not negative");

endmodule
